FILE: rtl/swrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrc_pkg
// Shared types and constants of the stop-and-wait retransmit control unit.
// ----------------------------------------------------------------------------
package swrc_pkg;

    localparam int TICKS_W    = 20;
    localparam int FAILS_W    = 4;
    localparam int ID_W       = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = TICKS_W;

    localparam logic [TICKS_W-1:0] TICKS_MAX     = '1;
    localparam logic [FAILS_W-1:0] FAILS_MAX     = '1;
    localparam logic [ID_W-1:0]    ID_MAX        = '1;
    localparam logic [TICKS_W-1:0] TIMEOUT_RESET = 20'd38400;
    localparam logic [FAILS_W-1:0] RETRY_RESET   = 4'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT = 1'd1;

    // acknowledge class that counts as a failure
    localparam logic [1:0] CLS_INVALID_PKT = 2'd1;

    typedef enum logic [2:0] {
        ACT_TICK  = 3'd0,
        ACT_POLL  = 3'd1,
        ACT_ACK   = 3'd2,
        ACT_ALLOC = 3'd3,
        ACT_INIT  = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_SEND    = 3'd1,
        EV_RESEND  = 3'd2,
        EV_GAVE_UP = 3'd3,
        EV_ID      = 3'd4
    } t_event;

    typedef struct packed {
        logic [2:0] action;
        logic       queue_not_empty;
        logic       ack_has_code;
        logic [1:0] ack_class;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_in_word;

    typedef struct packed {
        t_event            event_res;
        logic [ID_W-1:0]    packet_id;
        logic               waiting;
        logic [FAILS_W-1:0] retry_count;
    } t_result;

endpackage

FILE: rtl/swrc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrc_in_if / swrc_out_if
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface swrc_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic       queue_not_empty;
    logic       ack_has_code;
    logic [1:0] ack_class;

    modport source (output valid, action, queue_not_empty, ack_has_code, ack_class,
                    input ready);
    modport sink   (input valid, action, queue_not_empty, ack_has_code, ack_class,
                    output ready);
endinterface

interface swrc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_res;
    logic [7:0] packet_id;
    logic       waiting;
    logic [3:0] retry_count;

    modport source (output valid, event_res, packet_id, waiting, retry_count,
                    input ready);
    modport sink   (input valid, event_res, packet_id, waiting, retry_count,
                    output ready);
endinterface

FILE: rtl/swrc_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrc_in_stage
// Input register: takes a word whenever it is empty or moving on.
// ----------------------------------------------------------------------------
module swrc_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    swrc_in_if.sink             i_item,
    input  logic                i_advance,
    output swrc_pkg::t_in_word  o_word
);

    logic            r_valid;
    swrc_pkg::t_item r_item;
    logic            w_take;

    assign i_item.ready = !r_valid || i_advance;
    assign w_take       = i_item.valid && i_item.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.action          <= i_item.action;
            r_item.queue_not_empty <= i_item.queue_not_empty;
            r_item.ack_has_code    <= i_item.ack_has_code;
            r_item.ack_class       <= i_item.ack_class;
        end
    end

    assign o_word.valid = r_valid;
    assign o_word.item  = r_item;

endmodule

FILE: rtl/swrc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrc_core
// Link state, configuration registers and the per-word update.
// ----------------------------------------------------------------------------
module swrc_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_fire,
    input  swrc_pkg::t_item                     i_item,
    input  logic                                i_cfg_we,
    input  logic [swrc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [swrc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output swrc_pkg::t_result                   o_res
);

    logic [swrc_pkg::TICKS_W-1:0] r_timeout;
    logic [swrc_pkg::FAILS_W-1:0] r_retry_limit;

    logic                         r_await,  n_await;
    logic [swrc_pkg::FAILS_W-1:0] r_fail,   n_fail;
    logic [swrc_pkg::TICKS_W-1:0] r_ticks,  n_ticks;
    logic [swrc_pkg::ID_W-1:0]    r_id,     n_id;

    logic [swrc_pkg::FAILS_W-1:0] w_fail_inc;
    logic                         w_fail_path;
    swrc_pkg::t_event             w_event;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout     <= swrc_pkg::TIMEOUT_RESET;
            r_retry_limit <= swrc_pkg::RETRY_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                swrc_pkg::REG_ACK_TIMEOUT: r_timeout     <= i_cfg_data;
                swrc_pkg::REG_RETRY_LIMIT: r_retry_limit <= i_cfg_data[swrc_pkg::FAILS_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_fail_inc = (r_fail == swrc_pkg::FAILS_MAX) ? r_fail : r_fail + 4'd1;

    always_comb begin
        n_await     = r_await;
        n_fail      = r_fail;
        n_ticks     = r_ticks;
        n_id        = r_id;
        w_fail_path = 1'b0;
        w_event     = swrc_pkg::EV_NONE;
        unique case (swrc_pkg::t_action'(i_item.action))
            swrc_pkg::ACT_TICK: begin
                if (r_ticks != swrc_pkg::TICKS_MAX) begin
                    n_ticks = r_ticks + 20'd1;
                end
            end
            swrc_pkg::ACT_POLL: begin
                if (r_await) begin
                    w_fail_path = (r_ticks > r_timeout);
                end else if (i_item.queue_not_empty) begin
                    n_await = 1'b1;
                    n_ticks = '0;
                    n_fail  = '0;
                    w_event = swrc_pkg::EV_SEND;
                end
            end
            swrc_pkg::ACT_ACK: begin
                if (i_item.ack_has_code) begin
                    if (i_item.ack_class == swrc_pkg::CLS_INVALID_PKT) begin
                        w_fail_path = 1'b1;
                    end else begin
                        n_await = 1'b0;
                    end
                end
            end
            swrc_pkg::ACT_ALLOC: begin
                // ids wrap from 255 to 1, never 0
                n_id    = (r_id == swrc_pkg::ID_MAX) ? 8'd1 : r_id + 8'd1;
                w_event = swrc_pkg::EV_ID;
            end
            swrc_pkg::ACT_INIT: begin
                n_id = '0;
            end
            default: ;
        endcase
        if (w_fail_path) begin
            n_fail = w_fail_inc;
            if (w_fail_inc > r_retry_limit) begin
                n_await = 1'b0;
                w_event = swrc_pkg::EV_GAVE_UP;
            end else begin
                n_await = 1'b1;
                n_ticks = '0;
                w_event = swrc_pkg::EV_RESEND;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_await <= 1'b0;
            r_fail  <= '0;
            r_ticks <= '0;
            r_id    <= '0;
        end else if (i_fire) begin
            r_await <= n_await;
            r_fail  <= n_fail;
            r_ticks <= n_ticks;
            r_id    <= n_id;
        end
    end

    assign o_res.event_res   = w_event;
    assign o_res.packet_id   = n_id;
    assign o_res.waiting     = n_await;
    assign o_res.retry_count = n_fail;

endmodule

FILE: rtl/swrc_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrc_out_stage
// Result register holding one word until the sink takes it.
// ----------------------------------------------------------------------------
module swrc_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  swrc_pkg::t_result i_res,
    output logic              o_free,
    swrc_out_if.source        o_res
);

    logic              r_valid;
    swrc_pkg::t_result r_res;

    // free when empty or the held word leaves this cycle
    assign o_free = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_res.valid       = r_valid;
    assign o_res.event_res   = r_res.event_res;
    assign o_res.packet_id   = r_res.packet_id;
    assign o_res.waiting     = r_res.waiting;
    assign o_res.retry_count = r_res.retry_count;

endmodule

FILE: rtl/stop_and_wait_retransmit_control_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stop_and_wait_retransmit_control_unit
// Transmit-side retransmit control of a stop-and-wait link: send, timeout,
// resend or give up, and packet id allocation.
//
//   channel   dir  handshake          payload
//   i_item    in   valid/ready        action, queue_not_empty, ack_has_code, ack_class
//   o_res     out  valid/ready        event_res, packet_id, waiting, retry_count
//   config    in   i_cfg_we           i_cfg_idx, i_cfg_data
//
// One word per cycle while the result stage is not stalled; a result passes
// through the input register, then the state update into the result register,
// from which it is offered on o_res.
// Reset clears both stages and the link state and loads the register defaults.
// A stalled result holds the result register; the input register still takes
// one more word if it is empty, then input ready drops until the result moves on.
// ----------------------------------------------------------------------------
module stop_and_wait_retransmit_control_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    swrc_in_if.sink                         i_item,
    swrc_out_if.source                      o_res,
    input  logic                            i_cfg_we,
    input  logic [swrc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [swrc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    swrc_pkg::t_in_word w_word;
    swrc_pkg::t_result  w_res;
    logic               w_free;
    logic               w_fire;

    assign w_fire = w_word.valid && w_free;

    swrc_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .i_advance (w_free),
        .o_word    (w_word)
    );

    swrc_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (w_fire),
        .i_item     (w_word.item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_res      (w_res)
    );

    swrc_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_fire),
        .i_res   (w_res),
        .o_free  (w_free),
        .o_res   (o_res)
    );

`ifndef NO_ASSERTIONS
    // a new result only follows a held input word
    a_res_from_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> $past(w_word.valid))
        else $error("result appeared without an input word");

    // a held input word is not dropped while the result stage is blocked
    a_word_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_word.valid && !w_free |=> w_word.valid)
        else $error("input word lost under stall");

    // a send or resend leaves the link waiting, a give-up leaves it idle
    a_wait_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && (w_res.event_res == swrc_pkg::EV_SEND ||
                   w_res.event_res == swrc_pkg::EV_RESEND) |=> o_res.waiting)
        else $error("send without waiting flag");

    a_gave_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.event_res == swrc_pkg::EV_GAVE_UP |->
            !o_res.waiting && o_res.retry_count != '0)
        else $error("give-up with inconsistent state");

    // allocated ids are never zero
    a_id_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.event_res == swrc_pkg::EV_ID |-> o_res.packet_id != '0)
        else $error("zero packet id allocated");
`endif

endmodule
